@@ rtl/pwtm_pkg.sv @@
// Package for the post/wait tag match table.
// Holds opcode, status and state encodings and the controller/datapath
// command and status structs. No dependencies.
`default_nettype none

package pwtm_pkg;

  localparam int NODE_W = 16;
  localparam int TAG_W  = 32;
  localparam int HELD_W = 7;
  localparam int ENTRY_W = NODE_W + TAG_W;

  typedef enum logic [1:0] {
    OP_POST          = 2'd0,
    OP_WAIT_ANY      = 2'd1,
    OP_WAIT_NODE     = 2'd2,
    OP_WAIT_NODE_TAG = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_POSTED   = 2'd0,
    ST_MATCHED  = 2'd1,
    ST_NO_MATCH = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SRCH_RD,
    S_SRCH_CMP,
    S_MOVE_RD,
    S_MOVE_WR,
    S_FIN
  } ctrl_state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic    load_req;
    logic    cnt_inc;
    logic    cnt_dec;
    logic    ptr_load_top;
    logic    ptr_inc;
    logic    ptr_dec;
    logic    rd_en;
    logic    wr_post;
    logic    wr_shift;
    logic    set_status;
    status_t status_code;
    logic    load_out;
  } ctrl_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    op_t  op;
    logic count_full;
    logic count_zero;
    logic ptr_zero;
    logic ptr_at_count;
    logic hit;
    logic out_free;
  } ctrl_sts_t;

endpackage

`default_nettype wire

@@ rtl/post_wait_tag_match_table_top.sv @@
// Post/wait tag match table, top level. A node wait searches the notices newest first,
// reading then comparing each entry; on a hit it shifts each later entry down by one,
// reading it then writing it, and so closes the gap.
// One item in work at a time; the next is taken the cycle after its result loads.
// Reset (synchronous, rst_n low) empties the table; notice RAM is not cleared.
`default_nettype none

module post_wait_tag_match_table_top #(
  parameter int TABLE_DEPTH = 64
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [1:0]                        in_opcode,
  input  wire logic [pwtm_pkg::NODE_W-1:0]       in_source_node,
  input  wire logic signed [pwtm_pkg::TAG_W-1:0] in_match_tag,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic [1:0]                             out_status,
  output logic [pwtm_pkg::HELD_W-1:0]            out_entries_held
);

  pwtm_pkg::ctrl_cmd_t cmd;
  pwtm_pkg::ctrl_sts_t sts;

  pwtm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  pwtm_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_opcode        (in_opcode),
    .in_source_node   (in_source_node),
    .in_match_tag     (in_match_tag),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_entries_held (out_entries_held)
  );

  // Never grow a full table
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.cnt_inc |-> !sts.count_full)
    else $error("count incremented on a full table");

  // Never shrink an empty table
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.cnt_dec |-> !sts.count_zero)
    else $error("count decremented on an empty table");

  // Result loaded only into a free output register
  a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> sts.out_free)
    else $error("result register overwritten");

  // One item in work at a time
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("second item taken while busy");

endmodule

`default_nettype wire

@@ rtl/pwtm_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module pwtm_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

@@ rtl/pwtm_dp.sv @@
// Datapath of the tag match table: request, count, pointer, notice RAM
// and result register. Depends on pwtm_pkg and pwtm_ram.
`default_nettype none

module pwtm_dp #(
  parameter int TABLE_DEPTH = 64
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire pwtm_pkg::ctrl_cmd_t          cmd,
  output pwtm_pkg::ctrl_sts_t               sts,
  input  wire logic [1:0]                   in_opcode,
  input  wire logic [pwtm_pkg::NODE_W-1:0]  in_source_node,
  input  wire logic signed [pwtm_pkg::TAG_W-1:0] in_match_tag,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic [1:0]                        out_status,
  output logic [pwtm_pkg::HELD_W-1:0]       out_entries_held
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int HW = pwtm_pkg::HELD_W;
  localparam int NW = pwtm_pkg::NODE_W;
  localparam int TW = pwtm_pkg::TAG_W;
  localparam int EW = pwtm_pkg::ENTRY_W;

  pwtm_pkg::op_t     req_op_r;
  logic [NW-1:0]     req_node_r;
  logic [TW-1:0]     req_tag_r;
  logic [CW-1:0]     count_r, count_nxt;
  logic [CW-1:0]     ptr_r, ptr_nxt;
  logic [CW-1:0]     ptr_m1;
  pwtm_pkg::status_t status_r;
  logic              out_valid_r;
  logic [1:0]        out_status_r;
  logic [HW-1:0]     out_held_r;

  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [EW-1:0]     wr_data;
  logic [EW-1:0]     rd_data;
  logic [NW-1:0]     rd_node;
  logic [TW-1:0]     rd_tag;

  // Capture the request
  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_op_r   <= pwtm_pkg::op_t'(in_opcode);
      req_node_r <= in_source_node;
      req_tag_r  <= in_match_tag;
    end
  end

  // Notice count
  always_comb begin
    count_nxt = count_r;
    if (cmd.cnt_inc) begin
      count_nxt = count_r + CW'(1);
    end else if (cmd.cnt_dec) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // Search / move pointer
  assign ptr_m1 = ptr_r - CW'(1);

  always_comb begin
    ptr_nxt = ptr_r;
    if (cmd.ptr_load_top) begin
      ptr_nxt = count_r - CW'(1);
    end else if (cmd.ptr_inc) begin
      ptr_nxt = ptr_r + CW'(1);
    end else if (cmd.ptr_dec) begin
      ptr_nxt = ptr_m1;
    end
  end

  always_ff @(posedge clk) begin
    ptr_r <= ptr_nxt;
  end

  // Result status
  always_ff @(posedge clk) begin
    if (cmd.set_status) begin
      status_r <= cmd.status_code;
    end
  end

  // Notice RAM: append at the tail, or shift an entry down by one
  assign wr_en   = cmd.wr_post | cmd.wr_shift;
  assign wr_addr = cmd.wr_post ? count_r[AW-1:0] : ptr_m1[AW-1:0];
  assign wr_data = cmd.wr_post ? {req_node_r, req_tag_r} : rd_data;

  pwtm_ram #(
    .WIDTH (EW),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (cmd.rd_en),
    .rd_addr (ptr_r[AW-1:0]),
    .rd_data (rd_data)
  );

  assign rd_node = rd_data[EW-1 -: NW];
  assign rd_tag  = rd_data[TW-1:0];

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_status_r <= status_r;
      out_held_r   <= HW'(count_r);
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_entries_held = out_held_r;

  // Status back to the controller
  always_comb begin
    sts.op           = req_op_r;
    sts.count_full   = (count_r == CW'(TABLE_DEPTH));
    sts.count_zero   = (count_r == '0);
    sts.ptr_zero     = (ptr_r == '0);
    sts.ptr_at_count = (ptr_r == count_r);
    sts.hit          = (rd_node == req_node_r) &&
                       ((req_op_r != pwtm_pkg::OP_WAIT_NODE_TAG) || (rd_tag == req_tag_r));
    sts.out_free     = !out_valid_r || !out_stall;
  end

endmodule

`default_nettype wire

@@ rtl/pwtm_ctrl.sv @@
// Controller state machine of the tag match table: sequences post, wait,
// backward search and gap closing. Depends on pwtm_pkg.
`default_nettype none

module pwtm_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire pwtm_pkg::ctrl_sts_t sts,
  output pwtm_pkg::ctrl_cmd_t      cmd
);

  pwtm_pkg::ctrl_state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pwtm_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = (state_r != pwtm_pkg::S_IDLE);
    unique case (state_r)
      pwtm_pkg::S_IDLE: begin
        // take one item
        if (in_valid) begin
          cmd.load_req = 1'b1;
          state_nxt    = pwtm_pkg::S_EXEC;
        end
      end
      pwtm_pkg::S_EXEC: begin
        cmd.set_status = 1'b1;
        state_nxt      = pwtm_pkg::S_FIN;
        unique case (sts.op)
          pwtm_pkg::OP_POST: begin
            if (sts.count_full) begin
              cmd.status_code = pwtm_pkg::ST_FULL;
            end else begin
              cmd.wr_post     = 1'b1;
              cmd.cnt_inc     = 1'b1;
              cmd.status_code = pwtm_pkg::ST_POSTED;
            end
          end
          pwtm_pkg::OP_WAIT_ANY: begin
            if (sts.count_zero) begin
              cmd.status_code = pwtm_pkg::ST_NO_MATCH;
            end else begin
              cmd.cnt_dec     = 1'b1;
              cmd.status_code = pwtm_pkg::ST_MATCHED;
            end
          end
          default: begin
            // node or node+tag wait: start at the newest notice
            if (sts.count_zero) begin
              cmd.status_code = pwtm_pkg::ST_NO_MATCH;
            end else begin
              cmd.set_status   = 1'b0;
              cmd.ptr_load_top = 1'b1;
              state_nxt        = pwtm_pkg::S_SRCH_RD;
            end
          end
        endcase
      end
      pwtm_pkg::S_SRCH_RD: begin
        cmd.rd_en = 1'b1;
        state_nxt = pwtm_pkg::S_SRCH_CMP;
      end
      pwtm_pkg::S_SRCH_CMP: begin
        if (sts.hit) begin
          // found: shift the later notices down over it
          cmd.ptr_inc = 1'b1;
          state_nxt   = pwtm_pkg::S_MOVE_RD;
        end else if (sts.ptr_zero) begin
          cmd.set_status  = 1'b1;
          cmd.status_code = pwtm_pkg::ST_NO_MATCH;
          state_nxt       = pwtm_pkg::S_FIN;
        end else begin
          cmd.ptr_dec = 1'b1;
          state_nxt   = pwtm_pkg::S_SRCH_RD;
        end
      end
      pwtm_pkg::S_MOVE_RD: begin
        if (sts.ptr_at_count) begin
          cmd.cnt_dec     = 1'b1;
          cmd.set_status  = 1'b1;
          cmd.status_code = pwtm_pkg::ST_MATCHED;
          state_nxt       = pwtm_pkg::S_FIN;
        end else begin
          cmd.rd_en = 1'b1;
          state_nxt = pwtm_pkg::S_MOVE_WR;
        end
      end
      pwtm_pkg::S_MOVE_WR: begin
        cmd.wr_shift = 1'b1;
        cmd.ptr_inc  = 1'b1;
        state_nxt    = pwtm_pkg::S_MOVE_RD;
      end
      pwtm_pkg::S_FIN: begin
        // hand the result over once the output register frees up
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = pwtm_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = pwtm_pkg::S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ tb/post_wait_tag_match_table_top_tb.sv @@
// Self-checking testbench for post_wait_tag_match_table_top: directed rows, then
// random phases that fill, mix and drain the notice table under random idling.
// Depends on pwtm_pkg and the top-level RTL only.
module post_wait_tag_match_table_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pwtm_pkg::*;

  localparam int DEPTH      = 64;
  localparam int RAND_ITEMS = 1250;
  localparam int LONG_HOLD  = 400;
  localparam int DRAIN_TAIL = 300;
  localparam int DIR_N      = 21;

  typedef struct packed {
    status_t            status;
    logic [HELD_W-1:0]  held;
  } reply_t;

  // one directed row; typed rows carry their own expected reply
  typedef struct packed {
    op_t                op;
    logic [NODE_W-1:0]  node;
    logic [TAG_W-1:0]   tag;
    logic               typed;
    status_t            status;
    logic [HELD_W-1:0]  held;
  } dir_row_t;

  localparam dir_row_t DIR_TAB [DIR_N] = '{
    '{OP_WAIT_ANY,      16'h0000, 32'h0000_0000, 1'b1, ST_NO_MATCH, 7'd0},
    '{OP_WAIT_NODE,     16'hffff, 32'hffff_ffff, 1'b1, ST_NO_MATCH, 7'd0},
    '{OP_WAIT_NODE_TAG, 16'h0000, 32'h0000_0000, 1'b1, ST_NO_MATCH, 7'd0},
    '{OP_POST,          16'h0000, 32'h8000_0000, 1'b1, ST_POSTED,   7'd1},
    '{OP_POST,          16'hffff, 32'h7fff_ffff, 1'b1, ST_POSTED,   7'd2},
    '{OP_POST,          16'hffff, 32'hffff_ffff, 1'b1, ST_POSTED,   7'd3},
    '{OP_POST,          16'h0000, 32'h0000_0000, 1'b1, ST_POSTED,   7'd4},
    '{OP_POST,          16'h5555, 32'haaaa_aaaa, 1'b1, ST_POSTED,   7'd5},
    // remove from the middle, then from the bottom of the table
    '{OP_WAIT_NODE_TAG, 16'hffff, 32'h7fff_ffff, 1'b0, ST_POSTED,   7'd0},
    '{OP_WAIT_NODE_TAG, 16'h0000, 32'h8000_0000, 1'b0, ST_POSTED,   7'd0},
    // misses: unknown node, node with wrong tag, tag off by its sign bit
    '{OP_WAIT_NODE,     16'h1234, 32'h0000_0000, 1'b0, ST_POSTED,   7'd0},
    '{OP_WAIT_NODE_TAG, 16'h0000, 32'h0000_0001, 1'b0, ST_POSTED,   7'd0},
    '{OP_WAIT_NODE_TAG, 16'h5555, 32'h2aaa_aaaa, 1'b0, ST_POSTED,   7'd0},
    '{OP_WAIT_NODE,     16'h0000, 32'hdead_beef, 1'b0, ST_POSTED,   7'd0},
    '{OP_POST,          16'haaaa, 32'h5555_5555, 1'b0, ST_POSTED,   7'd0},
    '{OP_POST,          16'hffff, 32'h0000_0000, 1'b0, ST_POSTED,   7'd0},
    '{OP_WAIT_NODE,     16'hffff, 32'h0000_0000, 1'b0, ST_POSTED,   7'd0},
    '{OP_WAIT_ANY,      16'h0000, 32'h0000_0000, 1'b0, ST_POSTED,   7'd0},
    '{OP_WAIT_NODE_TAG, 16'h5555, 32'haaaa_aaaa, 1'b0, ST_POSTED,   7'd0},
    '{OP_WAIT_ANY,      16'h0000, 32'h0000_0000, 1'b0, ST_POSTED,   7'd0},
    '{OP_WAIT_ANY,      16'hffff, 32'hffff_ffff, 1'b1, ST_NO_MATCH, 7'd0}
  };

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  logic [1:0]          in_opcode;
  logic [NODE_W-1:0]   in_source_node;
  logic [TAG_W-1:0]    in_match_tag;
  logic                out_valid;
  logic                out_stall;
  logic [1:0]          out_status;
  logic [HELD_W-1:0]   out_entries_held;

  // mirror of the notice table, oldest entry at index 0
  logic [NODE_W-1:0]   mirror_node [DEPTH];
  logic [TAG_W-1:0]    mirror_tag  [DEPTH];
  int                  mirror_cnt = 0;

  reply_t              reply_q [$];
  int                  err_cnt = 0;
  bit                  no_idle = 1'b0;
  bit                  hold_req = 1'b0;

  post_wait_tag_match_table_top #(.TABLE_DEPTH(DEPTH)) DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_opcode        (in_opcode),
    .in_source_node   (in_source_node),
    .in_match_tag     (in_match_tag),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_entries_held (out_entries_held)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Apply one item to the mirror table and return its status.
  function automatic status_t table_apply(input op_t op, input logic [NODE_W-1:0] node,
                                          input logic [TAG_W-1:0] tag);
    int      hit;
    status_t st;
    hit = -1;
    case (op)
      OP_POST: begin
        if (mirror_cnt >= DEPTH) begin
          st = ST_FULL;
        end else begin
          mirror_node[mirror_cnt] = node;
          mirror_tag[mirror_cnt]  = tag;
          mirror_cnt++;
          st = ST_POSTED;
        end
      end
      OP_WAIT_ANY: begin
        if (mirror_cnt > 0) begin
          mirror_cnt--;
          st = ST_MATCHED;
        end else begin
          st = ST_NO_MATCH;
        end
      end
      default: begin
        // search newest first, then close the gap
        for (int i = mirror_cnt - 1; i >= 0 && hit < 0; i--)
          if (mirror_node[i] == node && (op == OP_WAIT_NODE || mirror_tag[i] == tag))
            hit = i;
        if (hit < 0) begin
          st = ST_NO_MATCH;
        end else begin
          for (int j = hit; j < mirror_cnt - 1; j++) begin
            mirror_node[j] = mirror_node[j + 1];
            mirror_tag[j]  = mirror_tag[j + 1];
          end
          mirror_cnt--;
          st = ST_MATCHED;
        end
      end
    endcase
    return st;
  endfunction

  // Offer one item from a falling edge, hold it until taken, then idle for a random gap, which may be zero.
  task automatic offer_item(input op_t op, input logic [NODE_W-1:0] node,
                            input logic [TAG_W-1:0] tag, input logic typed,
                            input status_t typed_st, input logic [HELD_W-1:0] typed_held);
    reply_t r;
    int     gap;
    in_valid       <= 1'b1;
    in_opcode      <= op;
    in_source_node <= node;
    in_match_tag   <= tag;
    do @(posedge clk); while (in_stall !== 1'b0);
    r.status = table_apply(op, node, tag);
    r.held   = HELD_W'(mirror_cnt);
    if (typed) begin
      r.status = typed_st;
      r.held   = typed_held;
    end
    reply_q.push_back(r);
    @(negedge clk);
    gap = no_idle ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // Drop valid and hold off until every reply has come back.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (reply_q.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // Draw one random item; most waits aim at a notice that is held.
  task automatic pick_item(input int post_pct, output op_t op,
                           output logic [NODE_W-1:0] node, output logic [TAG_W-1:0] tag);
    int idx;
    if ($urandom_range(0, 99) < post_pct) op = OP_POST;
    else op = op_t'($urandom_range(1, 3));
    if ($urandom_range(0, 3) == 0) node = NODE_W'($urandom);
    else node = NODE_W'($urandom_range(0, 7));
    case ($urandom_range(0, 5))
      0:       tag = 32'h8000_0000;
      1:       tag = 32'h7fff_ffff;
      2:       tag = 32'hffff_ffff;
      3:       tag = $urandom;
      default: tag = $urandom_range(0, 3);
    endcase
    if (op != OP_POST && mirror_cnt > 0 && $urandom_range(0, 3) != 0) begin
      idx  = $urandom_range(0, mirror_cnt - 1);
      node = mirror_node[idx];
      tag  = mirror_tag[idx];
      if ($urandom_range(0, 4) == 0) tag = tag ^ (32'h1 << $urandom_range(0, 31));
    end
  endtask

  initial begin : stimulus
    int                 sent;
    int                 phase;
    int                 kind;
    int                 len;
    int                 post_pct;
    op_t                op;
    logic [NODE_W-1:0]  node;
    logic [TAG_W-1:0]   tag;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_opcode      = '0;
    in_source_node = '0;
    in_match_tag   = '0;
    sent           = 0;
    phase          = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // walk the directed rows
    for (int k = 0; k < DIR_N; k++)
      offer_item(DIR_TAB[k].op, DIR_TAB[k].node, DIR_TAB[k].tag, DIR_TAB[k].typed,
                 DIR_TAB[k].status, DIR_TAB[k].held);
    wait_drained();

    // random phases: fill to full and beyond, mixed traffic, drain past empty
    while (sent < RAND_ITEMS) begin
      kind    = (phase == 0) ? 0 : $urandom_range(0, 2);
      no_idle = ($urandom_range(0, 3) == 0);
      case (kind)
        0: begin post_pct = 90; len = $urandom_range(60, 110); end
        1: begin post_pct = 50; len = $urandom_range(20, 60); end
        default: begin post_pct = 10; len = $urandom_range(40, 100); end
      endcase
      if (phase == 2 || phase == 7) hold_req = 1'b1;
      for (int k = 0; k < len; k++) begin
        pick_item(post_pct, op, node, tag);
        offer_item(op, node, tag, 1'b0, ST_POSTED, '0);
        sent++;
      end
      if (phase == 4 || $urandom_range(0, 4) == 0) wait_drained();
      phase++;
    end
    no_idle = 1'b0;
    in_valid <= 1'b0;

    while (reply_q.size() != 0) @(posedge clk);
    repeat (DRAIN_TAIL) @(posedge clk);
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Result side: random stall per item, one long hold when asked.
  initial begin : result_sink
    int n;
    out_stall = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if (hold_req) begin
        n = LONG_HOLD;
        hold_req = 1'b0;
      end else begin
        n = no_idle ? 0 : $urandom_range(0, 7);
      end
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (out_valid !== 1'b1);
      @(negedge clk);
    end
  end

  // Compare each accepted result with the oldest expected reply.
  always @(posedge clk) begin
    reply_t e;
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (reply_q.size() == 0) begin
        $display("%0t: unexpected result status=%0d held=%0d", $time, out_status,
                 out_entries_held);
        err_cnt++;
      end else begin
        e = reply_q.pop_front();
        if (out_status !== e.status) begin
          $display("%0t: status mismatch: expected %0d, actual %0d", $time, e.status,
                   out_status);
          err_cnt++;
        end
        if (out_entries_held !== e.held) begin
          $display("%0t: entries_held mismatch: expected %0d, actual %0d", $time, e.held,
                   out_entries_held);
          err_cnt++;
        end
      end
    end
  end

  // Hard stop well past the slowest legal run
  initial begin
    #20_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

@@ files.f @@
rtl/pwtm_pkg.sv
rtl/pwtm_ram.sv
rtl/pwtm_dp.sv
rtl/pwtm_ctrl.sv
rtl/post_wait_tag_match_table_top.sv
tb/post_wait_tag_match_table_top_tb.sv
